/* sv/tvn_pkg.sv */
// Shared widths and constants for the triangle vertex normal pipeline.
package tvn_pkg;

	localparam int SLOT_W   = 12;  // slot field width
	localparam int EDGE_W   = 33;  // raw edge difference
	localparam int RED_W    = 31;  // edge after range reduction
	localparam int PROD_W   = 62;  // cross product partial product
	localparam int NRM_W    = 63;  // cross product component
	localparam int AMAG_W   = 62;  // magnitude of a cross product component
	localparam int BLEN_W   = 6;   // bit length of up to 62 bits
	localparam int NORM_BITS = 30; // target bit length after scaling
	localparam int SC_W     = 31;  // scaled component, signed
	localparam int SUM_W    = 62;  // sum of squares
	localparam int ROOT_W   = 31;  // square root of the sum
	localparam int QUO_W    = 16;  // quotient per component
	localparam int REM_W    = 33;  // division remainder
	localparam int Q_FRAC   = 16;  // quotient bits produced by the divider

	localparam logic [QUO_W-1:0] Q15_MAX = 16'd32767;

	typedef logic [SC_W-1:0] mag_t;
	typedef logic [QUO_W-1:0] quo_t;

endpackage

/* sv/tvn_isqrt.sv */
// Pipelined integer square root, one root bit per stage, with side payload.
module tvn_isqrt
	import tvn_pkg::*;
#(
	parameter int PAY_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [SUM_W-1:0]      in_value,
	input  logic [PAY_W-1:0]      in_pay,
	output logic                  out_valid,
	output logic [ROOT_W-1:0]     out_root,
	output logic [PAY_W-1:0]      out_pay
);

	localparam int STEPS = SUM_W / 2;

	logic                 vld_s  [0:STEPS];
	logic [ROOT_W+1:0]    rem_s  [0:STEPS];
	logic [ROOT_W-1:0]    root_s [0:STEPS];
	logic [SUM_W-1:0]     val_s  [0:STEPS];
	logic [PAY_W-1:0]     pay_s  [0:STEPS];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign val_s[0]  = in_value;
	assign pay_s[0]  = in_pay;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam int K = STEPS - 1 - i;
		logic [ROOT_W+3:0] rr;
		logic [ROOT_W+3:0] trial;
		logic              take;

		// bring down the next bit pair and try the next root bit
		always_comb begin
			rr    = {rem_s[i], val_s[i][2*K+1 -: 2]};
			trial = {1'b0, root_s[i], 2'b01};
			take  = (rr >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? (ROOT_W+2)'(rr - trial) : (ROOT_W+2)'(rr);
				root_s[i+1] <= {root_s[i][ROOT_W-2:0], take};
				val_s[i+1]  <= val_s[i];
				pay_s[i+1]  <= pay_s[i];
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_root  = root_s[STEPS];
	assign out_pay   = pay_s[STEPS];

endmodule

/* sv/tvn_div.sv */
// Pipelined restoring divider, three lanes: q = (a*2^16 + m) / (2*m).
module tvn_div
	import tvn_pkg::*;
#(
	parameter int PAY_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  mag_t [2:0]            in_a,
	input  logic [ROOT_W-1:0]     in_mag,
	input  logic [PAY_W-1:0]      in_pay,
	output logic                  out_valid,
	output quo_t [2:0]            out_q,
	output logic [PAY_W-1:0]      out_pay
);

	logic                        vld_s [0:Q_FRAC];
	logic [2:0][REM_W-1:0]       rem_s [0:Q_FRAC];
	logic [2:0][QUO_W-1:0]       quo_s [0:Q_FRAC];
	logic [ROOT_W:0]             den_s [0:Q_FRAC];
	logic [Q_FRAC-1:0]           low_s [0:Q_FRAC];
	logic [PAY_W-1:0]            pay_s [0:Q_FRAC];

	// setup: high part of the dividend is a + m/2^16, low part is m[15:0]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= REM_W'(in_a[l]) + REM_W'(in_mag >> Q_FRAC);
				quo_s[0][l] <= '0;
			end
			den_s[0] <= {in_mag, 1'b0};
			low_s[0] <= in_mag[Q_FRAC-1:0];
			pay_s[0] <= in_pay;
		end
	end

	for (genvar j = 0; j < Q_FRAC; j++) begin : g_step
		logic [2:0][REM_W:0]   sh;
		logic [2:0]            take;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				sh[l]   = {rem_s[j][l], low_s[j][Q_FRAC-1-j]};
				take[l] = (sh[l] >= (REM_W+1)'(den_s[j]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[j+1][l] <= take[l] ? REM_W'(sh[l] - (REM_W+1)'(den_s[j]))
						: REM_W'(sh[l]);
					quo_s[j+1][l] <= {quo_s[j][l][QUO_W-2:0], take[l]};
				end
				den_s[j+1] <= den_s[j];
				low_s[j+1] <= low_s[j];
				pay_s[j+1] <= pay_s[j];
			end
		end
	end

	assign out_valid = vld_s[Q_FRAC];
	assign out_q     = quo_s[Q_FRAC];
	assign out_pay   = pay_s[Q_FRAC];

endmodule

/* sv/triangle_vertex_normals_top.sv */
// Triangle face normal pipeline: edges, cross product, scaling, root, divide, per-corner output.
// Stages: 10 front stages, 31 square-root stages, 17 divider stages and an output register; the
// three corner results of a triangle then leave one corner per cycle while m_tready is high.
// The output register takes a new triangle only when it is empty or its last corner is accepted.
// The whole pipeline holds while a finished triangle waits for the busy output register.
// Reset clears the valid bits of every stage and the output register; data registers keep.
module triangle_vertex_normals_top
	import tvn_pkg::*;
#(
	parameter int SLOT_COUNT  = 4096,
	parameter int COORD_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// first_slot, second_slot, third_slot, first_x..z, second_x..z, third_x..z, zero pad
	input  logic [((3*SLOT_W+9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// corner_slot, normal_x, normal_y, normal_z, zero pad
	output logic [63:0]           m_tdata,
	// degenerate
	output logic                  m_tuser,
	output logic                  m_tlast
);

	localparam int RECIP_SH = 24;
	localparam logic [RECIP_SH-1:0] SLOT_RECIP = RECIP_SH'((64'd1 << RECIP_SH) / SLOT_COUNT);
	localparam logic [20:0] SLOT_C = 21'(SLOT_COUNT);
	localparam int ISQ_PAY_W = 1 + 3 + 3*SC_W + 3*SLOT_W;
	localparam int DIV_PAY_W = 1 + 3 + 3*SLOT_W;

	logic en;

	// ---------------- stage 1: edges, slot quotient estimate
	logic                                v_s1;
	logic signed [EDGE_W-1:0]            e_s1 [0:5];
	logic [SLOT_W-1:0]                   slot_s1 [0:2];
	logic [SLOT_W-1:0]                   sq_s1 [0:2];
	logic signed [EDGE_W-1:0]            pin [0:8];
	logic [SLOT_W+RECIP_SH-1:0]          sprod [0:2];

	always_comb begin
		for (int j = 0; j < 9; j++) begin
			pin[j] = EDGE_W'($signed(s_tdata[3*SLOT_W + j*COORD_WIDTH +: COORD_WIDTH]));
		end
		for (int k = 0; k < 3; k++) begin
			sprod[k] = (SLOT_W+RECIP_SH)'(s_tdata[k*SLOT_W +: SLOT_W]) *
				(SLOT_W+RECIP_SH)'(SLOT_RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e_s1[i]     <= pin[3+i] - pin[i];
				e_s1[3+i]   <= pin[6+i] - pin[3+i];
				slot_s1[i]  <= s_tdata[i*SLOT_W +: SLOT_W];
				sq_s1[i]    <= sprod[i][SLOT_W+RECIP_SH-1:RECIP_SH];
			end
		end
	end

	// ---------------- stage 2: edge range reduction, slot remainder
	logic                                v_s2;
	logic signed [RED_W-1:0]             e_s2 [0:5];
	logic [SLOT_W-1:0]                   sr_s2 [0:2];
	logic [EDGE_W-1:0]                   emag [0:5];
	logic [EDGE_W-1:0]                   eor;
	logic [1:0]                          esh;
	logic [31:0]                         qm [0:2];
	logic [31:0]                         sdiff [0:2];

	always_comb begin
		eor = '0;
		for (int i = 0; i < 6; i++) begin
			emag[i] = e_s1[i][EDGE_W-1] ? EDGE_W'(-e_s1[i]) : EDGE_W'(e_s1[i]);
			eor     = eor | emag[i];
		end
		if (eor[NORM_BITS+2]) begin
			esh = 2'd3;
		end else if (eor[NORM_BITS+1]) begin
			esh = 2'd2;
		end else if (eor[NORM_BITS]) begin
			esh = 2'd1;
		end else begin
			esh = 2'd0;
		end
		for (int k = 0; k < 3; k++) begin
			qm[k]    = 32'(sq_s1[k]) * 32'(SLOT_C);
			sdiff[k] = 32'(slot_s1[k]) - qm[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				e_s2[i] <= RED_W'(e_s1[i] >>> esh);
			end
			for (int k = 0; k < 3; k++) begin
				sr_s2[k] <= sdiff[k][SLOT_W-1:0];
			end
		end
	end

	// ---------------- stage 3: cross product partial products, slot correction
	logic                                v_s3;
	logic signed [PROD_W-1:0]            p_s3 [0:5];
	logic [SLOT_W-1:0]                   slot_s3 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3[0] <= e_s2[1] * e_s2[5];
			p_s3[1] <= e_s2[2] * e_s2[4];
			p_s3[2] <= e_s2[2] * e_s2[3];
			p_s3[3] <= e_s2[0] * e_s2[5];
			p_s3[4] <= e_s2[0] * e_s2[4];
			p_s3[5] <= e_s2[1] * e_s2[3];
			for (int k = 0; k < 3; k++) begin
				slot_s3[k] <= (21'(sr_s2[k]) >= SLOT_C) ? SLOT_W'(21'(sr_s2[k]) - SLOT_C)
					: sr_s2[k];
			end
		end
	end

	// ---------------- stage 4: cross product components
	logic                                v_s4;
	logic signed [NRM_W-1:0]             n_s4 [0:2];
	logic [SLOT_W-1:0]                   slot_s4 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s4[i]    <= NRM_W'(p_s3[2*i]) - NRM_W'(p_s3[2*i+1]);
				slot_s4[i] <= slot_s3[i];
			end
		end
	end

	// ---------------- stage 5: magnitudes, zero-area detect
	logic                                v_s5;
	logic signed [NRM_W-1:0]             n_s5 [0:2];
	logic [AMAG_W-1:0]                   or_s5;
	logic                                dg_s5;
	logic [SLOT_W-1:0]                   slot_s5 [0:2];
	logic [AMAG_W-1:0]                   nmag [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmag[i] = n_s4[i][NRM_W-1] ? AMAG_W'(-n_s4[i]) : AMAG_W'(n_s4[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5    <= n_s4;
			or_s5   <= nmag[0] | nmag[1] | nmag[2];
			dg_s5   <= (n_s4[0] == '0) && (n_s4[1] == '0) && (n_s4[2] == '0);
			slot_s5 <= slot_s4;
		end
	end

	// ---------------- stage 6: bit length of the largest magnitude
	logic                                v_s6;
	logic signed [NRM_W-1:0]             n_s6 [0:2];
	logic [BLEN_W-1:0]                   bl_s6;
	logic                                dg_s6;
	logic [SLOT_W-1:0]                   slot_s6 [0:2];
	logic [BLEN_W-1:0]                   blen;

	always_comb begin
		blen = '0;
		for (int b = 0; b < AMAG_W; b++) begin
			if (or_s5[b]) begin
				blen = BLEN_W'(b + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6    <= n_s5;
			bl_s6   <= blen;
			dg_s6   <= dg_s5;
			slot_s6 <= slot_s5;
		end
	end

	// ---------------- stage 7: scale to 30 significant bits
	logic                                v_s7;
	logic signed [SC_W-1:0]              sc_s7 [0:2];
	logic                                dg_s7;
	logic [SLOT_W-1:0]                   slot_s7 [0:2];
	logic                                down;
	logic [BLEN_W-1:0]                   dsh;
	logic [BLEN_W-1:0]                   ush;

	always_comb begin
		down = (bl_s6 > BLEN_W'(NORM_BITS));
		dsh  = bl_s6 - BLEN_W'(NORM_BITS);
		ush  = BLEN_W'(NORM_BITS) - bl_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sc_s7[i] <= down ? SC_W'(n_s6[i] >>> dsh) : SC_W'(n_s6[i] <<< ush);
			end
			dg_s7   <= dg_s6;
			slot_s7 <= slot_s6;
		end
	end

	// ---------------- stage 8: component magnitudes and signs
	logic                                v_s8;
	mag_t                                a_s8 [0:2];
	logic [2:0]                          sg_s8;
	logic                                dg_s8;
	logic [SLOT_W-1:0]                   slot_s8 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s8[i]  <= sc_s7[i][SC_W-1] ? SC_W'(-sc_s7[i]) : SC_W'(sc_s7[i]);
				sg_s8[i] <= sc_s7[i][SC_W-1];
			end
			dg_s8   <= dg_s7;
			slot_s8 <= slot_s7;
		end
	end

	// ---------------- stage 9: squares
	logic                                v_s9;
	logic [SUM_W-1:0]                    sq_s9 [0:2];
	mag_t                                a_s9 [0:2];
	logic [2:0]                          sg_s9;
	logic                                dg_s9;
	logic [SLOT_W-1:0]                   slot_s9 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s9[i] <= SUM_W'(a_s8[i]) * SUM_W'(a_s8[i]);
			end
			a_s9    <= a_s8;
			sg_s9   <= sg_s8;
			dg_s9   <= dg_s8;
			slot_s9 <= slot_s8;
		end
	end

	// ---------------- stage 10: sum of squares
	logic                                v_s10;
	logic [SUM_W-1:0]                    sum_s10;
	logic [ISQ_PAY_W-1:0]                pay_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s10 <= sq_s9[0] + sq_s9[1] + sq_s9[2];
			pay_s10 <= {dg_s9, sg_s9, a_s9[2], a_s9[1], a_s9[0],
				slot_s9[2], slot_s9[1], slot_s9[0]};
		end
	end

	// ---------------- square root of the sum
	logic                                isq_v;
	logic [ROOT_W-1:0]                   isq_root;
	logic [ISQ_PAY_W-1:0]                isq_pay;
	mag_t [2:0]                          isq_a;

	tvn_isqrt #(
		.PAY_W (ISQ_PAY_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.in_value  (sum_s10),
		.in_pay    (pay_s10),
		.out_valid (isq_v),
		.out_root  (isq_root),
		.out_pay   (isq_pay)
	);

	assign isq_a = isq_pay[3*SLOT_W +: 3*SC_W];

	// ---------------- per-component division by the magnitude
	logic                                div_v;
	quo_t [2:0]                          div_q;
	logic [DIV_PAY_W-1:0]                div_pay;

	tvn_div #(
		.PAY_W (DIV_PAY_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (isq_v),
		.in_a      (isq_a),
		.in_mag    (isq_root),
		.in_pay    ({isq_pay[ISQ_PAY_W-1 -: 4], isq_pay[3*SLOT_W-1:0]}),
		.out_valid (div_v),
		.out_q     (div_q),
		.out_pay   (div_pay)
	);

	// ---------------- saturation, sign and output register
	logic                                dg_f;
	logic [2:0]                          sg_f;
	logic [QUO_W-1:0]                    nq_f [0:2];
	logic [QUO_W-1:0]                    qs;

	always_comb begin
		dg_f = div_pay[DIV_PAY_W-1];
		sg_f = div_pay[DIV_PAY_W-2 -: 3];
		for (int i = 0; i < 3; i++) begin
			qs = (div_q[i] > Q15_MAX) ? Q15_MAX : div_q[i];
			if (dg_f) begin
				nq_f[i] = '0;
			end else if (sg_f[i]) begin
				nq_f[i] = QUO_W'(-qs);
			end else begin
				nq_f[i] = qs;
			end
		end
	end

	logic                                out_v_q;
	logic [1:0]                          cnt_q;
	logic [SLOT_W-1:0]                   slot_q [0:2];
	logic [QUO_W-1:0]                    nx_q;
	logic [QUO_W-1:0]                    ny_q;
	logic [QUO_W-1:0]                    nz_q;
	logic                                dg_q;
	logic                                out_done;
	logic                                take;
	logic                                last_c;

	assign last_c   = (cnt_q == 2'd2);
	assign out_done = out_v_q && m_tready && last_c;
	assign take     = !out_v_q || out_done;
	assign en       = take || !div_v;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else if (take && div_v) begin
			out_v_q <= 1'b1;
			cnt_q   <= 2'd0;
		end else if (out_v_q && m_tready) begin
			if (last_c) begin
				out_v_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && div_v) begin
			for (int k = 0; k < 3; k++) begin
				slot_q[k] <= div_pay[k*SLOT_W +: SLOT_W];
			end
			nx_q <= nq_f[0];
			ny_q <= nq_f[1];
			nz_q <= nq_f[2];
			dg_q <= dg_f;
		end
	end

	// corner select for the output transaction
	logic [SLOT_W-1:0] cur_slot;

	always_comb begin
		case (cnt_q)
			2'd0:    cur_slot = slot_q[0];
			2'd1:    cur_slot = slot_q[1];
			default: cur_slot = slot_q[2];
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0, nz_q, ny_q, nx_q, cur_slot};
	assign m_tuser  = dg_q;
	assign m_tlast  = last_c;

endmodule

/* sim/triangle_vertex_normals_top_test.sv */
// Self-checking testbench for the triangle vertex normal pipeline.
`timescale 1ns / 1ps

module triangle_vertex_normals_top_test;
	import tvn_pkg::*;

	localparam int CW        = 24;
	localparam int IN_W      = ((3*SLOT_W+9*CW+7)/8)*8;
	localparam int IDLE_LIMIT = 5000;
	localparam int RAND_ITEMS = 480;
	localparam int QUIET_TAIL = 60;

	typedef struct {
		logic [SLOT_W-1:0]   slot [3];
		logic signed [CW-1:0] coord [9];  // x,y,z of first, second, third corner
	} face_t;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [15:0]       nx, ny, nz;
		logic              degen, last;
	} corner_t;

	typedef struct {
		face_t       face;
		bit          typed;        // expected normal given by hand
		logic [15:0] nx, ny, nz;
		logic        degen;
	} vec_row_t;

	logic            clk, arst_n;
	logic            s_tvalid, s_tready;
	logic [IN_W-1:0] s_tdata;
	logic            m_tvalid, m_tready;
	logic [63:0]     m_tdata;
	logic            m_tuser, m_tlast;

	corner_t expected_corners [$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	bit      quiet = 0;
	int      rx_hold = 0;

	triangle_vertex_normals_top #(.SLOT_COUNT(4096), .COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int bit_length(longint unsigned v);
		int n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-(v + 1)) + 1 : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Unit face normal, the same for all three corners
	function automatic void face_normal(face_t f, output logic [15:0] q [3], output logic degen);
		longint p [9];
		longint e [6];
		longint n [3];
		longint unsigned m, sum, root, a, r;
		int b;
		for (int i = 0; i < 9; i++) p[i] = f.coord[i];
		for (int i = 0; i < 3; i++) begin
			e[i]   = p[3+i] - p[i];
			e[3+i] = p[6+i] - p[3+i];
		end
		// edge range reduction, floor shift
		m = 0;
		for (int i = 0; i < 6; i++) if (magnitude(e[i]) > m) m = magnitude(e[i]);
		b = bit_length(m);
		if (b > NORM_BITS) for (int i = 0; i < 6; i++) e[i] = e[i] >>> (b - NORM_BITS);
		n[0] = e[1]*e[5] - e[2]*e[4];
		n[1] = e[2]*e[3] - e[0]*e[5];
		n[2] = e[0]*e[4] - e[1]*e[3];
		q[0] = 0; q[1] = 0; q[2] = 0;
		degen = (n[0] == 0 && n[1] == 0 && n[2] == 0);
		if (degen) return;
		// bring area vector to exactly NORM_BITS bits
		m = 0;
		for (int i = 0; i < 3; i++) if (magnitude(n[i]) > m) m = magnitude(n[i]);
		b = bit_length(m);
		for (int i = 0; i < 3; i++)
			if (b > NORM_BITS) n[i] = n[i] >>> (b - NORM_BITS);
			else n[i] = n[i] <<< (NORM_BITS - b);
		sum = 0;
		for (int i = 0; i < 3; i++) sum += magnitude(n[i]) * magnitude(n[i]);
		root = int_sqrt(sum);
		if (root == 0) root = 1;
		for (int i = 0; i < 3; i++) begin
			a = magnitude(n[i]);
			r = (a * 65536 + root) / (2 * root);
			if (r > Q15_MAX) r = Q15_MAX;
			q[i] = (n[i] < 0) ? 16'(-r) : 16'(r);
		end
	endfunction

	function automatic void queue_corners(face_t f, logic [15:0] q [3], logic degen);
		corner_t c;
		for (int k = 0; k < 3; k++) begin
			c.slot = f.slot[k];
			c.nx = q[0]; c.ny = q[1]; c.nz = q[2];
			c.degen = degen;
			c.last = (k == 2);
			expected_corners.push_back(c);
		end
	endfunction

	function automatic logic [IN_W-1:0] pack_face(face_t f);
		logic [IN_W-1:0] d = '0;
		for (int k = 0; k < 3; k++) d[k*SLOT_W +: SLOT_W] = f.slot[k];
		for (int i = 0; i < 9; i++) d[3*SLOT_W + i*CW +: CW] = f.coord[i];
		return d;
	endfunction

	// Send one triangle; the expectation is queued at the accepting edge
	task automatic send_face(face_t f, bit typed, logic [15:0] q [3], logic degen,
			bit allow_gap);
		logic [15:0] pq [3];
		logic pd;
		if (allow_gap && !quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pack_face(f);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (typed) queue_corners(f, q, degen);
		else begin
			face_normal(f, pq, pd);
			queue_corners(f, pq, pd);
		end
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		return CW'($urandom);
	endfunction

	function automatic face_t rand_face(int kind);
		face_t f;
		for (int k = 0; k < 3; k++) f.slot[k] = SLOT_W'($urandom);
		case (kind)
			0: for (int i = 0; i < 9; i++) f.coord[i] = rand_coord();
			1: begin
				// small triangle around a random base
				for (int i = 0; i < 3; i++) f.coord[i] = rand_coord();
				for (int i = 3; i < 9; i++)
					f.coord[i] = f.coord[i%3] + CW'($urandom_range(0, 1023)) - 512;
			end
			2: begin
				// collinear corners
				for (int i = 0; i < 6; i++) f.coord[i] = CW'($urandom_range(0, 65535)) - 32768;
				for (int i = 6; i < 9; i++)
					f.coord[i] = f.coord[i-3] + (f.coord[i-3] - f.coord[i-6]) * 2;
			end
			default: begin
				// two coincident corners
				for (int i = 0; i < 6; i++) f.coord[i] = rand_coord();
				for (int i = 6; i < 9; i++) f.coord[i] = f.coord[i-3];
			end
		endcase
		return f;
	endfunction

	function automatic face_t make_face(logic [SLOT_W-1:0] s0, s1, s2,
			int x0, y0, z0, x1, y1, z1, x2, y2, z2);
		face_t f;
		f.slot[0] = s0; f.slot[1] = s1; f.slot[2] = s2;
		f.coord[0] = x0; f.coord[1] = y0; f.coord[2] = z0;
		f.coord[3] = x1; f.coord[4] = y1; f.coord[5] = z1;
		f.coord[6] = x2; f.coord[7] = y2; f.coord[8] = z2;
		return f;
	endfunction

	// Receiver: random stall bursts until the quiet tail
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b1;
			rx_hold  <= 0;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_hold  <= $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each corner transaction against the oldest expectation
	always @(posedge clk) begin
		corner_t c;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_corners.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected corner: %h", m_tdata);
			end else begin
				c = expected_corners.pop_front();
				if (m_tdata[11:0] !== c.slot || m_tdata[27:12] !== c.nx ||
					m_tdata[43:28] !== c.ny || m_tdata[59:44] !== c.nz ||
					m_tdata[63:60] !== 4'd0 || m_tuser !== c.degen || m_tlast !== c.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("corner mismatch: exp slot %0d n %h %h %h dg %b l %b, got slot %0d n %h %h %h dg %b l %b",
							c.slot, c.nx, c.ny, c.nz, c.degen, c.last,
							m_tdata[11:0], m_tdata[27:12], m_tdata[43:28], m_tdata[59:44],
							m_tuser, m_tlast);
				end
			end
		end
	end

	// Watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		vec_row_t    vectors [$];
		vec_row_t    row;
		logic [15:0] q [3];
		int          lo, hi;
		lo = -(1 << 23);
		hi = (1 << 23) - 1;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b1;

		// directed rows: typed ones first, then predicted extremes
		row.typed = 1; row.degen = 0; row.nx = 0; row.ny = 0; row.nz = 16'd32767;
		row.face = make_face(0, 1, 2, 0, 0, 0, 1, 0, 0, 1, 1, 0);
		vectors.push_back(row);
		row.face = make_face(4095, 4094, 4093, lo, lo, lo, hi, lo, lo, hi, hi, lo);
		vectors.push_back(row);
		row.nz = 16'(-32767);
		row.face = make_face(7, 8, 9, 0, 0, 0, 0, 1, 0, 1, 1, 0);
		vectors.push_back(row);
		row.nz = 0; row.nx = 16'd32767;
		row.face = make_face(100, 200, 300, 0, 0, 0, 0, 1, 0, 0, 1, 1);
		vectors.push_back(row);
		row.nx = 0; row.ny = 16'd32767;
		row.face = make_face(1, 1, 1, 0, 0, 0, 0, 0, 1, 1, 0, 1);
		vectors.push_back(row);
		row.ny = 0; row.degen = 1;
		row.face = make_face(4095, 0, 4095, hi, hi, hi, hi, hi, hi, hi, hi, hi);
		vectors.push_back(row);
		row.face = make_face(0, 4095, 0, lo, lo, lo, lo, lo, lo, lo, lo, lo);
		vectors.push_back(row);
		row.face = make_face(5, 6, 7, 0, 0, 0, 1, 1, 1, 2, 2, 2);
		vectors.push_back(row);
		row.face = make_face(5, 6, 7, lo, lo, lo, hi, hi, hi, hi, hi, hi);
		vectors.push_back(row);
		row.typed = 0;
		row.face = make_face(2730, 1365, 3000, hi, lo, hi, lo, hi, lo, hi, hi, lo);
		vectors.push_back(row);
		row.face = make_face(11, 12, 13, lo, hi, lo, hi, lo, lo, lo, lo, hi);
		vectors.push_back(row);
		row.face = make_face(21, 22, 23, lo, 0, hi, hi, 0, lo, 0, hi, 0);
		vectors.push_back(row);
		row.face = make_face(31, 32, 33, 0, 0, 0, 1, 2, 3, -3, 5, -7);
		vectors.push_back(row);
		row.face = make_face(41, 42, 43, -1, -1, -1, 65536, 0, 0, 0, 65536, 65536);
		vectors.push_back(row);
		row.face = make_face(51, 52, 53, 0, 0, 0, 1, 1, 0, 1, 0, 1);
		vectors.push_back(row);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i]) begin
			q[0] = vectors[i].nx; q[1] = vectors[i].ny; q[2] = vectors[i].nz;
			send_face(vectors[i].face, vectors[i].typed, q, vectors[i].degen, 1);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			int kind;
			kind = $urandom_range(0, 9);
			kind = (kind < 5) ? 0 : (kind < 8) ? 1 : (kind == 8) ? 2 : 3;
			if (n == RAND_ITEMS / 2) begin
				// hold off until the pipeline has drained
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (expected_corners.size() != 0) @(posedge clk);
			end
			if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1;
			send_face(rand_face(kind), 0, q, 1'b0, 1);
		end
		s_tvalid <= 1'b0;

		while (expected_corners.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
sv/tvn_pkg.sv
sv/tvn_isqrt.sv
sv/tvn_div.sv
sv/triangle_vertex_normals_top.sv
sim/triangle_vertex_normals_top_test.sv
